### sv/midi_message_assembler_defines.svh
// Assertion macros shared by the assembler RTL.
`ifndef MIDI_MESSAGE_ASSEMBLER_DEFINES_SVH
`define MIDI_MESSAGE_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("midi_message_assembler: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("midi_message_assembler: check failed");

`endif

### sv/mma_pkg.sv
package mma_pkg;

	// Status nibbles and system bytes that the parser decodes.
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_CHAN_PRS = 4'hD;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;

	localparam logic [7:0] SYS_SYSEX_START = 8'hF0;
	localparam logic [7:0] SYS_MTC_QUARTER = 8'hF1;
	localparam logic [7:0] SYS_SONG_POS    = 8'hF2;
	localparam logic [7:0] SYS_SONG_SELECT = 8'hF3;
	localparam logic [7:0] SYS_SYSEX_END   = 8'hF7;

	// Byte counts of a message, status included.
	localparam logic [1:0] COUNT_ONE   = 2'd1;
	localparam logic [1:0] COUNT_TWO   = 2'd2;
	localparam logic [1:0] COUNT_THREE = 2'd3;

	// Data bytes a status byte asks for.
	localparam logic [1:0] NEED_ONE = 2'd1;
	localparam logic [1:0] NEED_TWO = 2'd2;

	// Input word: one raw byte.
	typedef struct packed {
		logic [7:0] midi_byte;
	} byte_word_t;

	// Output word: one complete message.
	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] first_data;
		logic [6:0] second_data;
		logic [1:0] byte_count;
	} msg_word_t;

	// Parser result handed to the output register.
	typedef struct packed {
		logic      emit;
		msg_word_t msg;
	} parse_result_t;

endpackage

### sv/mma_stream_if.sv
// Valid/ready channel that moves one word per handshake.
interface mma_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/mma_parser.sv
// Parser state and decode: consumes one byte per enabled cycle.
module mma_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             midi_byte,
	output mma_pkg::parse_result_t result
);
	logic [7:0] held_status_q;
	logic [6:0] held_first_data_q;
	logic [1:0] bytes_collected_q;
	logic [1:0] bytes_remaining_q;
	logic       in_sysex_q;

	logic [7:0] held_status_d;
	logic [6:0] held_first_data_d;
	logic [1:0] bytes_collected_d;
	logic [1:0] bytes_remaining_d;
	logic       in_sysex_d;
	logic [1:0] remaining_dec;

	assign remaining_dec = bytes_remaining_q - 2'd1;

	// Next state and result for the byte in the input stage.
	always_comb begin
		held_status_d     = held_status_q;
		held_first_data_d = held_first_data_q;
		bytes_collected_d = bytes_collected_q;
		bytes_remaining_d = bytes_remaining_q;
		in_sysex_d        = in_sysex_q;
		result            = '0;

		if (!midi_byte[7]) begin
			// Data byte: dropped unless a message is open.
			if (bytes_remaining_q != 2'd0) begin
				bytes_remaining_d = remaining_dec;
				if (remaining_dec == 2'd0) begin
					result.emit            = 1'b1;
					result.msg.status_byte = held_status_q;
					if (bytes_collected_q[1]) begin
						result.msg.first_data  = held_first_data_q;
						result.msg.second_data = midi_byte[6:0];
						result.msg.byte_count  = mma_pkg::COUNT_THREE;
					end else begin
						result.msg.first_data = midi_byte[6:0];
						result.msg.byte_count = mma_pkg::COUNT_TWO;
					end
					bytes_collected_d = 2'd0;
				end else begin
					held_first_data_d = midi_byte[6:0];
					bytes_collected_d = bytes_collected_q + 2'd1;
				end
			end
		end else begin
			unique case (midi_byte[7:4])
				mma_pkg::NIB_SYSTEM: begin
					unique case (midi_byte)
						mma_pkg::SYS_SONG_POS: begin
							held_status_d     = midi_byte;
							held_first_data_d = '0;
							bytes_collected_d = 2'd1;
							bytes_remaining_d = mma_pkg::NEED_TWO;
							in_sysex_d        = 1'b0;
						end
						mma_pkg::SYS_MTC_QUARTER, mma_pkg::SYS_SONG_SELECT: begin
							held_status_d     = midi_byte;
							held_first_data_d = '0;
							bytes_collected_d = 2'd1;
							bytes_remaining_d = mma_pkg::NEED_ONE;
							in_sysex_d        = 1'b0;
						end
						mma_pkg::SYS_SYSEX_START: begin
							in_sysex_d        = 1'b1;
							bytes_remaining_d = 2'd0;
							bytes_collected_d = 2'd0;
						end
						mma_pkg::SYS_SYSEX_END: begin
							// End of SysEx; outside SysEx it changes nothing.
							in_sysex_d = 1'b0;
						end
						default: begin
							// Every other system byte, real-time and undefined ones included, goes out at once.
							result.emit            = 1'b1;
							result.msg.status_byte = midi_byte;
							result.msg.byte_count  = mma_pkg::COUNT_ONE;
						end
					endcase
				end
				mma_pkg::NIB_PROGRAM, mma_pkg::NIB_CHAN_PRS: begin
					held_status_d     = midi_byte;
					held_first_data_d = '0;
					bytes_collected_d = 2'd1;
					bytes_remaining_d = mma_pkg::NEED_ONE;
					in_sysex_d        = 1'b0;
				end
				default: begin
					held_status_d     = midi_byte;
					held_first_data_d = '0;
					bytes_collected_d = 2'd1;
					bytes_remaining_d = mma_pkg::NEED_TWO;
					in_sysex_d        = 1'b0;
				end
			endcase
		end
	end

	// State registers update once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_status_q     <= '0;
			held_first_data_q <= '0;
			bytes_collected_q <= '0;
			bytes_remaining_q <= '0;
			in_sysex_q        <= 1'b0;
		end else if (advance) begin
			held_status_q     <= held_status_d;
			held_first_data_q <= held_first_data_d;
			bytes_collected_q <= bytes_collected_d;
			bytes_remaining_q <= bytes_remaining_d;
			in_sysex_q        <= in_sysex_d;
		end
	end
endmodule

### sv/mma_out_reg.sv
// Result register: holds one message word until the sink takes it.
module mma_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  mma_pkg::parse_result_t result,
	output logic                   can_load,
	mma_stream_if.source           message
);
	logic                valid_q;
	mma_pkg::msg_word_t  msg_q;

	// Room for a new word when empty or when the held word leaves now.
	assign can_load = !valid_q || message.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance && result.emit) begin
			valid_q <= 1'b1;
		end else if (message.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload carries no reset.
	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			msg_q <= result.msg;
		end
	end

	assign message.valid   = valid_q;
	assign message.payload = msg_q;
endmodule

### sv/midi_message_assembler.sv
// Path: an accepted byte waits in the input stage register; when the result register has room
// the parser decodes it, and a completed message word is loaded there for the sink to take.
// Throughput: one byte per cycle while the result register has room; the input register
// and the result register let a new byte enter while a finished message waits for the sink.
// Reset: arst_n clears the parser state and both valid flags at once; payloads keep
// whatever they hold.
`include "midi_message_assembler_defines.svh"

module midi_message_assembler (
	input  logic       clk,
	input  logic       arst_n,
	mma_stream_if.sink   midi,
	mma_stream_if.source message
);
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	logic                   can_load;
	mma_pkg::parse_result_t result;

	// The byte in the input stage is consumed when the result register has room.
	assign advance    = valid_s1 && can_load;
	assign midi.ready = !valid_s1 || can_load;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (midi.valid && midi.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (midi.valid && midi.ready) begin
			byte_s1 <= midi.payload.midi_byte;
		end
	end

	mma_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.midi_byte (byte_s1),
		.result    (result)
	);

	mma_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.result   (result),
		.can_load (can_load),
		.message  (message)
	);

	// A stalled input stage keeps its byte.
	`MMA_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1))
	// Every emitted word carries a status byte and a count of at least one.
	`MMA_ASSERT_IMPL(a_msg_shape, clk, arst_n, message.valid,
		message.payload.status_byte[7] && (message.payload.byte_count != 2'd0))
	// One-byte messages have both data fields clear.
	`MMA_ASSERT_IMPL(a_single_clear, clk, arst_n,
		message.valid && (message.payload.byte_count == mma_pkg::COUNT_ONE),
		(message.payload.first_data == 7'd0) && (message.payload.second_data == 7'd0))
	// A word with a result is consumed only when the result register can take it.
	`MMA_ASSERT_IMPL(a_no_overwrite, clk, arst_n, advance && result.emit,
		!message.valid || message.ready)
endmodule

### test/midi_message_assembler_tb.sv
module midi_message_assembler_tb;

	localparam int MAX_GAP        = 17;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 150;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int MAX_REPORTS    = 10;

	// Channel nibbles and single-byte system codes used by the stimulus.
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CONTROL  = 4'hB;
	localparam logic [3:0] NIB_PITCH    = 4'hE;
	localparam logic [7:0] SYS_UNDEF_F4 = 8'hF4;
	localparam logic [7:0] RT_CLOCK     = 8'hF8;
	localparam logic [7:0] RT_RESET     = 8'hFF;

	// One byte to send, with an optional hand-written expectation.
	typedef struct {
		logic [7:0]         value;
		bit                 typed;
		bit                 typed_emit;
		mma_pkg::msg_word_t typed_msg;
	} byte_row_t;

	logic clk;
	logic arst_n;

	mma_stream_if #(.payload_t(mma_pkg::byte_word_t)) midi_ch ();
	mma_stream_if #(.payload_t(mma_pkg::msg_word_t))  msg_ch ();

	midi_message_assembler DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.midi    (midi_ch),
		.message (msg_ch)
	);

	byte_row_t          byte_rows[$];
	byte_row_t          cur_row;
	mma_pkg::msg_word_t expected_msgs[$];

	// Shadow copy of the parser state.
	logic [7:0] asm_status    = '0;
	logic [6:0] asm_first     = '0;
	logic [1:0] asm_collected = '0;
	logic [1:0] asm_remaining = '0;
	logic       asm_sysex     = 1'b0;

	int fail_count  = 0;
	int bytes_taken = 0;
	int msgs_taken  = 0;
	int len_count[4];
	int idle_cycles = 0;

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Start collecting a new message.
	function automatic void open_msg(input logic [7:0] st, input logic [1:0] need);
		asm_status    = st;
		asm_first     = '0;
		asm_collected = mma_pkg::COUNT_ONE;
		asm_remaining = need;
		asm_sysex     = 1'b0;
	endfunction

	// Advance the shadow parser by one byte; returns 1 when a message completes.
	function automatic bit assemble_byte(input logic [7:0] b, output mma_pkg::msg_word_t m);
		m = '0;
		if (!b[7]) begin
			if (asm_remaining == 2'd0)
				return 1'b0;
			asm_remaining = asm_remaining - 2'd1;
			if (asm_remaining == 2'd0) begin
				m.status_byte = asm_status;
				if (asm_collected >= mma_pkg::COUNT_TWO) begin
					m.first_data  = asm_first;
					m.second_data = b[6:0];
					m.byte_count  = mma_pkg::COUNT_THREE;
				end else begin
					m.first_data = b[6:0];
					m.byte_count = mma_pkg::COUNT_TWO;
				end
				asm_collected = 2'd0;
				return 1'b1;
			end
			asm_first     = b[6:0];
			asm_collected = asm_collected + 2'd1;
			return 1'b0;
		end
		if (b[7:4] == mma_pkg::NIB_SYSTEM) begin
			case (b)
				mma_pkg::SYS_SONG_POS: open_msg(b, mma_pkg::NEED_TWO);
				mma_pkg::SYS_MTC_QUARTER, mma_pkg::SYS_SONG_SELECT:
					open_msg(b, mma_pkg::NEED_ONE);
				mma_pkg::SYS_SYSEX_START: begin
					asm_sysex     = 1'b1;
					asm_remaining = 2'd0;
					asm_collected = 2'd0;
				end
				mma_pkg::SYS_SYSEX_END: asm_sysex = 1'b0;
				default: begin
					m.status_byte = b;
					m.byte_count  = mma_pkg::COUNT_ONE;
					return 1'b1;
				end
			endcase
			return 1'b0;
		end
		if (b[7:4] == mma_pkg::NIB_PROGRAM || b[7:4] == mma_pkg::NIB_CHAN_PRS)
			open_msg(b, mma_pkg::NEED_ONE);
		else
			open_msg(b, mma_pkg::NEED_TWO);
		return 1'b0;
	endfunction

	// Any byte that is passed straight through as a one-byte message.
	function automatic logic [7:0] pick_immediate();
		int v;
		v = $urandom_range(0, 10);
		return (v < 3) ? SYS_UNDEF_F4 + 8'(v) : RT_CLOCK + 8'(v - 3);
	endfunction

	task automatic add_plain(input logic [7:0] value);
		byte_row_t row;
		row       = '{default: '0};
		row.value = value;
		byte_rows.push_back(row);
	endtask

	task automatic add_checked(input logic [7:0] value, input bit emit, input logic [7:0] st,
			input logic [6:0] d1, input logic [6:0] d2, input logic [1:0] n);
		byte_row_t row;
		row                       = '{default: '0};
		row.value                 = value;
		row.typed                 = 1'b1;
		row.typed_emit            = emit;
		row.typed_msg.status_byte = st;
		row.typed_msg.first_data  = d1;
		row.typed_msg.second_data = d2;
		row.typed_msg.byte_count  = n;
		byte_rows.push_back(row);
	endtask

	// Check each delivered message and predict from each accepted byte.
	always @(posedge clk) begin
		mma_pkg::msg_word_t want;
		mma_pkg::msg_word_t pred;
		mma_pkg::msg_word_t got;
		bit                 emitted;
		if (arst_n) begin
			if (msg_ch.valid && msg_ch.ready) begin
				got = msg_ch.payload;
				msgs_taken++;
				len_count[got.byte_count]++;
				if (expected_msgs.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected message: status %02h data %02h %02h count %0d",
							got.status_byte, got.first_data, got.second_data, got.byte_count);
				end else begin
					want = expected_msgs.pop_front();
					if (got.status_byte != want.status_byte || got.first_data != want.first_data
							|| got.second_data != want.second_data
							|| got.byte_count != want.byte_count) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display(
								"mismatch: expected %02h %02h %02h %0d, got %02h %02h %02h %0d",
								want.status_byte, want.first_data, want.second_data,
								want.byte_count, got.status_byte, got.first_data,
								got.second_data, got.byte_count);
					end
				end
			end
			if (midi_ch.valid && midi_ch.ready) begin
				bytes_taken++;
				emitted = assemble_byte(cur_row.value, pred);
				if (cur_row.typed) begin
					if (cur_row.typed_emit)
						expected_msgs.push_back(cur_row.typed_msg);
				end else if (emitted) begin
					expected_msgs.push_back(pred);
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((midi_ch.valid && midi_ch.ready) || (msg_ch.valid && msg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles, %0d messages outstanding",
					idle_cycles, expected_msgs.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Message sink with random stalls and one long hold-off.
	initial begin
		int  gap;
		bit  calm;
		bit  held;
		calm = 1'b0;
		held = 1'b0;
		msg_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && msgs_taken >= HOLD_AFTER) begin
				held = 1'b1;
				msg_ch.ready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (gap > 0) begin
				msg_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			msg_ch.ready <= 1'b1;
			@(posedge clk);
			while (!msg_ch.valid)
				@(posedge clk);
		end
	end

	// Byte source: directed table, random messages, then drain and report.
	initial begin
		int         pick;
		int         need;
		int         gap;
		int         n_data;
		int         sel;
		int         directed_rows;
		bit         calm;
		logic [3:0] nib;
		logic [7:0] st;

		arst_n = 1'b0;
		midi_ch.valid = 1'b0;
		midi_ch.payload = '0;
		cur_row = '{default: '0};
		calm = 1'b0;
		foreach (len_count[i])
			len_count[i] = 0;

		// Directed part.
		add_checked(8'h00, 1'b0, '0, '0, '0, '0);      // stray data after reset
		add_checked(RT_CLOCK, 1'b1, RT_CLOCK, '0, '0, mma_pkg::COUNT_ONE);
		add_plain({NIB_NOTE_ON, 4'h0});
		add_plain(8'h7F);
		add_checked(8'h00, 1'b1, {NIB_NOTE_ON, 4'h0}, 7'h7F, 7'h00, mma_pkg::COUNT_THREE);
		add_checked(8'h55, 1'b0, '0, '0, '0, '0);      // no running status
		add_plain({mma_pkg::NIB_PROGRAM, 4'hF});
		add_checked(8'h7F, 1'b1, {mma_pkg::NIB_PROGRAM, 4'hF}, 7'h7F, 7'h00,
			mma_pkg::COUNT_TWO);
		add_plain({NIB_PITCH, 4'h5});
		add_plain(8'h10);
		add_checked(RT_RESET, 1'b1, RT_RESET, '0, '0, mma_pkg::COUNT_ONE);  // mid-message
		add_plain(8'h20);
		add_plain({NIB_CONTROL, 4'h0});
		add_plain(8'h11);
		add_plain({NIB_NOTE_OFF, 4'hF});                // new status mid-message
		add_plain(8'h12);
		add_plain(8'h13);
		add_plain(mma_pkg::SYS_SYSEX_START);
		add_checked(8'h33, 1'b0, '0, '0, '0, '0);      // dropped inside SysEx
		add_checked(SYS_UNDEF_F4, 1'b1, SYS_UNDEF_F4, '0, '0, mma_pkg::COUNT_ONE);
		add_plain(mma_pkg::SYS_SYSEX_END);
		add_plain(mma_pkg::SYS_SONG_POS);
		add_plain(8'h01);
		add_plain(mma_pkg::SYS_SYSEX_END);              // lone end keeps the partial
		add_plain(8'h02);
		add_plain(mma_pkg::SYS_MTC_QUARTER);
		add_plain(8'h7F);
		add_plain({mma_pkg::NIB_CHAN_PRS, 4'h0});
		add_plain(8'h00);
		directed_rows = byte_rows.size();

		// Random part: mostly well-formed messages, some broken ones and noise.
		while (byte_rows.size() < directed_rows + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if (pick < 66 || pick >= 72) begin
					nib  = 4'($urandom_range(8, 14));
					st   = {nib, 4'($urandom)};
					need = (nib == mma_pkg::NIB_PROGRAM || nib == mma_pkg::NIB_CHAN_PRS)
						? 1 : 2;
				end else begin
					sel  = $urandom_range(0, 2);
					st   = (sel == 0) ? mma_pkg::SYS_MTC_QUARTER
						: (sel == 1) ? mma_pkg::SYS_SONG_POS : mma_pkg::SYS_SONG_SELECT;
					need = (st == mma_pkg::SYS_SONG_POS) ? 2 : 1;
				end
				// A broken sequence stops one data byte short.
				if (pick >= 72)
					need = need - 1;
				add_plain(st);
				for (int k = 0; k < need; k++) begin
					if ($urandom_range(0, 9) == 0)
						add_plain(pick_immediate());
					add_plain({1'b0, 7'($urandom)});
				end
			end else if (pick < 83) begin
				add_plain(mma_pkg::SYS_SYSEX_START);
				n_data = $urandom_range(0, 6);
				for (int k = 0; k < n_data; k++) begin
					if ($urandom_range(0, 7) == 0)
						add_plain(pick_immediate());
					add_plain({1'b0, 7'($urandom)});
				end
				if ($urandom_range(0, 9) != 0)
					add_plain(mma_pkg::SYS_SYSEX_END);
			end else if (pick < 91) begin
				add_plain(pick_immediate());
			end else if (pick < 94) begin
				add_plain(mma_pkg::SYS_SYSEX_END);
			end else begin
				add_plain(8'($urandom));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Offer each word after a random gap and hold it until taken.
		foreach (byte_rows[i]) begin
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (gap > 0) begin
				midi_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			midi_ch.valid <= 1'b1;
			midi_ch.payload.midi_byte <= byte_rows[i].value;
			cur_row <= byte_rows[i];
			@(posedge clk);
			while (!midi_ch.ready)
				@(posedge clk);
		end
		midi_ch.valid <= 1'b0;

		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d bytes (%0d from the directed table) and checked %0d messages.",
			bytes_taken, directed_rows, msgs_taken);
		$display("Messages by length: %0d one-byte, %0d two-byte, %0d three-byte.",
			len_count[1], len_count[2], len_count[3]);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
